// ===== src/bfa_pkg.sv =====
`default_nettype none
package bfa_pkg;

  localparam int unsigned FRAME_COUNT = 65536;
  localparam int unsigned WORD_BITS   = 64;

  localparam int unsigned FRAME_W = 17;
  localparam logic [FRAME_W-1:0] USED_MAX = 17'h1ffff;

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_MARK  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef enum logic {
    CFG_RANGE_START = 1'b0,
    CFG_RANGE_END   = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_DIV_RS,
    S_DIV_RE,
    S_DIV_SF,
    S_A_RD,
    S_A_WAIT,
    S_A_BIT,
    S_W_RD,
    S_W_MOD,
    S_STAT,
    S_C_RD,
    S_C_ACC,
    S_DONE
  } state_e;

endpackage
`default_nettype wire

// ===== src/bfa_div.sv =====
`default_nettype none
module bfa_div
  import bfa_pkg::*;
#(
  parameter int DIVISOR = 64
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [FRAME_W-1:0]         dividend_i,
  output logic                            done_o,
  output logic [FRAME_W-1:0]              quot_o,
  output logic [$clog2(DIVISOR)-1:0]      rem_o
);

  localparam int SH = $clog2(DIVISOR);

  logic [FRAME_W-1:0] quot_q, quot_d;
  logic [SH-1:0]      rem_q, rem_d;
  logic               done_q;

  // power-of-two divisor: quotient is a shift, remainder a mask
  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    if (start_i) begin
      quot_d = dividend_i >> SH;
      rem_d  = dividend_i[SH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

// ===== src/bfa_map.sv =====
`default_nettype none
module bfa_map #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 64,
  parameter int AW    = 10
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== src/bitmap_frame_allocator_top.sv =====
`default_nettype none
// sequence: the divider splits range start and end into word and bit; allocate scans,
// reading each map word and testing its frames in turn, and marks the run word by word;
// free/mark first split the base frame too, then read and write each word touched; stats
// sum each map word in the range, then the result is loaded; one item at a time, the next
// taken in the cycle after that load; reset: async active low; a clearing pass zeroes the
// map and no item is accepted until it ends (config writes are taken throughout)
module bitmap_frame_allocator_top
  import bfa_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [16:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [15:0] base_frame_i,
  input  wire logic [16:0] run_len_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             status_o,
  output logic [15:0]      frame_o,
  output logic [16:0]      used_count_o,
  output logic [16:0]      total_frames_o
);

  localparam int MAP_WORDS = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BW        = $clog2(WORD_BITS);
  localparam int LAST_BITS = FRAME_COUNT - (MAP_WORDS - 1) * WORD_BITS;
  localparam logic [31:0] FRAMES = 32'(FRAME_COUNT);
  localparam logic [31:0] MAPW   = 32'(MAP_WORDS);

  state_e state_q, state_d;

  logic [16:0] rs_q, re_q;
  mode_e       mode_q, mode_d;
  logic [15:0] sf_q, sf_d;
  logic [16:0] count_q, count_d;
  logic        status_q, status_d;
  logic [15:0] frame_q, frame_d;
  logic        set_q, set_d;
  logic [16:0] wlo_q, wlo_d, whi_q, whi_d;
  logic [BW-1:0] blo_q, blo_d;
  logic [16:0] widx_q, widx_d;
  logic [BW-1:0] bidx_q, bidx_d;
  logic [16:0] f_q, f_d, frs_q, frs_d, run_q, run_d, rem_q, rem_d;
  logic [16:0] rsw_q, rsw_d;
  logic [BW-1:0] rsb_q, rsb_d;
  logic [WORD_BITS-1:0] word_q, word_d;
  logic [16:0] acc_q, acc_d;

  logic        out_valid_q, out_valid_d;
  logic        o_status_q, o_status_d;
  logic [15:0] o_frame_q, o_frame_d;
  logic [16:0] o_used_q, o_used_d, o_total_q, o_total_d;

  logic            div_start, div_done;
  logic [16:0]     div_in, div_q;
  logic [BW-1:0]   div_r;

  logic                 mem_we, mem_re;
  logic [AW-1:0]        mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata, rdata, mask;

  logic        bit_used, run_hit, f_last, word_end, in_map, w_last, c_more, alloc_go;
  logic        stat_go, load;
  logic [16:0] span, nxt_w;
  logic [BW-1:0] nxt_b;
  logic [17:0] acc_sum;

  function automatic logic [6:0] popcount(input logic [63:0] v);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) begin
      n = n + 7'(v[i]);
    end
    return n;
  endfunction

  bfa_div #(.DIVISOR(WORD_BITS)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .dividend_i(div_in),
    .done_o(div_done), .quot_o(div_q), .rem_o(div_r)
  );

  bfa_map #(.DEPTH(MAP_WORDS), .WIDTH(WORD_BITS), .AW(AW)) u_map (
    .clk_i,
    .we_i(mem_we), .waddr_i(mem_waddr), .wdata_i(mem_wdata),
    .re_i(mem_re), .raddr_i(mem_raddr), .rdata_o(rdata)
  );

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs_q <= 17'd0;
      re_q <= 17'd65536;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_RANGE_START) rs_q <= cfg_data_i;
      else re_q <= cfg_data_i;
    end
  end

  assign bit_used = word_q[bidx_q] || ({15'b0, f_q} >= FRAMES);
  assign run_hit  = !bit_used && (run_q + 17'd1 == count_q);
  assign f_last   = (f_q + 17'd1 >= re_q);
  assign word_end = (bidx_q == BW'(WORD_BITS - 1));
  assign in_map   = ({15'b0, widx_q} < MAPW);
  assign span     = 17'(WORD_BITS) - 17'(bidx_q);
  assign w_last   = (rem_q <= span);
  assign c_more   = (widx_q + 17'd1 < whi_q) && ({15'b0, widx_q} + 32'd1 < MAPW);
  assign alloc_go = (rs_q < re_q) && (count_q != 17'd0);
  assign stat_go  = (wlo_q < whi_q) && ({15'b0, wlo_q} < MAPW);
  assign nxt_w    = word_end ? widx_q + 17'd1 : widx_q;
  assign nxt_b    = word_end ? '0 : bidx_q + BW'(1);
  assign acc_sum  = {1'b0, acc_q} + 18'(popcount(64'(rdata)));
  assign load     = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // bits of the current word covered by the run, clipped at the map end
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      mask[b] = (17'(b) >= 17'(bidx_q)) && (17'(b) - 17'(bidx_q) < rem_q) &&
                (({15'b0, widx_q} != MAPW - 32'd1) || (b < LAST_BITS));
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLR:    if ({15'b0, widx_q} == MAPW - 32'd1) state_d = S_IDLE;
      S_IDLE:   if (in_valid_i) state_d = S_DIV_RS;
      S_DIV_RS: if (div_done) state_d = S_DIV_RE;
      S_DIV_RE: begin
        if (div_done) begin
          case (mode_q)
            MODE_ALLOC: state_d = alloc_go ? S_A_RD : S_STAT;
            MODE_FREE, MODE_MARK: state_d = S_DIV_SF;
            default: state_d = S_STAT;
          endcase
        end
      end
      S_DIV_SF: if (div_done) state_d = (count_q == 17'd0) ? S_STAT : S_W_RD;
      S_A_RD:   state_d = in_map ? S_A_WAIT : S_STAT;
      S_A_WAIT: state_d = S_A_BIT;
      S_A_BIT: begin
        if (run_hit) state_d = S_W_RD;
        else if (f_last) state_d = S_STAT;
        else if (word_end) state_d = S_A_RD;
      end
      S_W_RD:   state_d = in_map ? S_W_MOD : S_STAT;
      S_W_MOD:  state_d = w_last ? S_STAT : S_W_RD;
      S_STAT:   state_d = stat_go ? S_C_RD : S_DONE;
      S_C_RD:   state_d = S_C_ACC;
      S_C_ACC:  state_d = c_more ? S_C_RD : S_DONE;
      S_DONE:   if (load) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == S_IDLE);
    mode_d = mode_q;   sf_d = sf_q;     count_d = count_q;
    status_d = status_q; frame_d = frame_q; set_d = set_q;
    wlo_d = wlo_q;     blo_d = blo_q;   whi_d = whi_q;
    widx_d = widx_q;   bidx_d = bidx_q; f_d = f_q; frs_d = frs_q;
    run_d = run_q;     rem_d = rem_q;   rsw_d = rsw_q; rsb_d = rsb_q;
    word_d = word_q;   acc_d = acc_q;
    div_start = 1'b0;  div_in = rs_q;
    mem_we = 1'b0;     mem_re = 1'b0;
    mem_waddr = AW'(widx_q); mem_raddr = AW'(widx_q);
    mem_wdata = '0;
    case (state_q)
      S_CLR: begin
        mem_we = 1'b1;
        widx_d = widx_q + 17'd1;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          mode_d = mode_e'(mode_i);
          sf_d = base_frame_i;
          count_d = run_len_i;
          status_d = 1'b0;
          frame_d = '0;
          div_start = 1'b1;
        end
      end
      S_DIV_RS: begin
        if (div_done) begin
          wlo_d = div_q;
          blo_d = div_r;
          div_start = 1'b1;
          div_in = re_q;
        end
      end
      S_DIV_RE: begin
        if (div_done) begin
          whi_d = div_q;
          set_d = (mode_q != MODE_FREE);
          if (mode_q == MODE_ALLOC) begin
            status_d = !((rs_q < re_q) && (count_q == 17'd0));
            if ((rs_q < re_q) && (count_q == 17'd0)) frame_d = rs_q[15:0];
            widx_d = wlo_q; bidx_d = blo_q;
            rsw_d = wlo_q;  rsb_d = blo_q;
            f_d = rs_q; frs_d = rs_q; run_d = '0;
          end else if (mode_q == MODE_FREE || mode_q == MODE_MARK) begin
            div_start = 1'b1;
            div_in = {1'b0, sf_q};
          end
        end
      end
      S_DIV_SF: begin
        if (div_done) begin
          widx_d = div_q;
          bidx_d = div_r;
          rem_d = count_q;
        end
      end
      S_A_RD: mem_re = in_map;
      S_A_WAIT: word_d = rdata;
      S_A_BIT: begin
        if (bit_used) begin
          run_d = '0;
          frs_d = f_q + 17'd1;
          rsw_d = nxt_w;
          rsb_d = nxt_b;
        end else begin
          run_d = run_q + 17'd1;
        end
        if (run_hit) begin
          status_d = 1'b0;
          frame_d = frs_q[15:0];
          widx_d = rsw_q;
          bidx_d = rsb_q;
          rem_d = count_q;
        end else begin
          f_d = f_q + 17'd1;
          widx_d = nxt_w;
          bidx_d = nxt_b;
        end
      end
      S_W_RD: mem_re = in_map;
      S_W_MOD: begin
        mem_we = 1'b1;
        mem_wdata = set_q ? (rdata | mask) : (rdata & ~mask);
        rem_d = w_last ? 17'd0 : rem_q - span;
        widx_d = widx_q + 17'd1;
        bidx_d = '0;
      end
      S_STAT: begin
        widx_d = wlo_q;
        acc_d = '0;
      end
      S_C_RD: mem_re = 1'b1;
      S_C_ACC: begin
        acc_d = (acc_sum > {1'b0, USED_MAX}) ? USED_MAX : acc_sum[16:0];
        widx_d = widx_q + 17'd1;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = (out_valid_q && !out_ready_i) || load;
    o_status_d = o_status_q;
    o_frame_d  = o_frame_q;
    o_used_d   = o_used_q;
    o_total_d  = o_total_q;
    if (load) begin
      o_status_d = status_q;
      o_frame_d  = frame_q;
      o_used_d   = acc_q;
      o_total_d  = (re_q > rs_q) ? re_q - rs_q : 17'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      widx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      widx_q      <= widx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;   sf_q <= sf_d;     count_q <= count_d;
    status_q <= status_d; frame_q <= frame_d; set_q <= set_d;
    wlo_q <= wlo_d;     blo_q <= blo_d;   whi_q <= whi_d;
    bidx_q <= bidx_d;   f_q <= f_d;       frs_q <= frs_d;
    run_q <= run_d;     rem_q <= rem_d;   rsw_q <= rsw_d; rsb_q <= rsb_d;
    word_q <= word_d;   acc_q <= acc_d;
    o_status_q <= o_status_d; o_frame_q <= o_frame_d;
    o_used_q <= o_used_d;     o_total_q <= o_total_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = o_status_q;
  assign frame_o        = o_frame_q;
  assign used_count_o   = o_used_q;
  assign total_frames_o = o_total_q;

`ifndef SYNTHESIS
  a_no_item_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR) |-> !in_ready_o) else $error("item taken during clear");
  a_fail_frame_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (frame_o == 16'd0)) else $error("failed item has frame");
  a_write_in_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ({15'b0, widx_q} < MAPW)) else $error("map write out of range");
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re)) else $error("map read and write together");
`endif

endmodule
`default_nettype wire

// ===== tb/bitmap_frame_allocator_top_test.sv =====
`default_nettype none
module bitmap_frame_allocator_top_test;
  import bfa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    mode_e       mode;
    logic [15:0] base_frame;
    logic [16:0] run_len;
  } request_t;

  typedef struct packed {
    logic        status;
    logic [15:0] frame;
    logic [16:0] used_count;
    logic [16:0] total_frames;
  } grant_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = 1'b0;
  logic [16:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] mode_i = '0;
  logic [15:0] base_frame_i = '0;
  logic [16:0] run_len_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic status_o;
  logic [15:0] frame_o;
  logic [16:0] used_count_o;
  logic [16:0] total_frames_o;

  bitmap_frame_allocator_top dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow of the block
  logic [63:0] used_map [1024];
  logic [16:0] lo_frame = 17'd0;
  logic [16:0] hi_frame = 17'd65536;

  request_t pending[$];
  grant_t   grants_due[$];
  bit item_taken = 0;
  bit cfg_taken = 0;
  bit no_idle = 0;
  int hold_cycles = 0;
  int errors = 0;
  int n_items = 0, n_grants = 0, n_alloc_ok = 0, n_alloc_fail = 0, n_cfg = 0;
  longint cycles = 0;

  function automatic bit frame_busy(int unsigned f);
    if (f >= 65536) return 1'b1;
    return used_map[f >> 6][f & 63];
  endfunction

  function automatic void set_run(int unsigned first, int unsigned cnt, bit v);
    int unsigned f;
    for (int unsigned i = 0; i < cnt; i++) begin
      f = first + i;
      if (f < 65536) used_map[f >> 6][f & 63] = v;
    end
  endfunction

  function automatic grant_t allocate_frames(request_t rq);
    grant_t g;
    int unsigned rs, re, run_start, run, used;
    g = '0;
    rs = lo_frame;
    re = hi_frame;
    case (rq.mode)
      MODE_ALLOC: begin
        g.status = 1'b1;
        if (rs < re) begin
          if (rq.run_len == 0) begin
            g.status = 1'b0;
            g.frame = rs[15:0];
          end else begin
            run_start = rs;
            run = 0;
            for (int unsigned f = rs; f < re; f++) begin
              if (frame_busy(f)) begin
                run_start = f + 1;
                run = 0;
              end else begin
                run++;
                if (run == rq.run_len) begin
                  set_run(run_start, rq.run_len, 1'b1);
                  g.status = 1'b0;
                  g.frame = run_start[15:0];
                  break;
                end
              end
            end
          end
        end
      end
      MODE_FREE: set_run(rq.base_frame, rq.run_len, 1'b0);
      MODE_MARK: set_run(rq.base_frame, rq.run_len, 1'b1);
      default: ;
    endcase
    used = 0;
    for (int unsigned w = rs / 64; w < re / 64 && w < 1024; w++)
      used += $countones(used_map[w]);
    g.used_count = (used > 131071) ? 17'h1ffff : used[16:0];
    g.total_frames = (re > rs) ? 17'(re - rs) : 17'd0;
    return g;
  endfunction

  // prediction and checking at the rising edge
  always @(posedge clk_i) begin
    request_t rq;
    grant_t want;
    cycles++;
    if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_idx_e'(cfg_index_i) == CFG_RANGE_START) lo_frame = cfg_data_i;
      else hi_frame = cfg_data_i;
      cfg_taken = 1;
      n_cfg++;
    end
    if (in_valid_i && in_ready_o) begin
      rq = request_t'{mode_e'(mode_i), base_frame_i, run_len_i};
      want = allocate_frames(rq);
      if (rq.mode == MODE_ALLOC) begin
        if (want.status) n_alloc_fail++;
        else n_alloc_ok++;
      end
      grants_due.push_back(want);
      item_taken = 1;
      n_items++;
    end
    if (out_valid_o && out_ready_i) begin
      n_grants++;
      if (grants_due.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        want = grants_due.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          errors++;
        end
        if (frame_o !== want.frame) begin
          $error("frame: expected %0d, got %0d", want.frame, frame_o);
          errors++;
        end
        if (used_count_o !== want.used_count) begin
          $error("used_count: expected %0d, got %0d", want.used_count, used_count_o);
          errors++;
        end
        if (total_frames_o !== want.total_frames) begin
          $error("total_frames: expected %0d, got %0d", want.total_frames, total_frames_o);
          errors++;
        end
      end
    end
    if (cycles > 40000000) begin
      $display("timeout after %0d cycles", cycles);
      $display("bitmap_frame_allocator_top: mismatch");
      $finish;
    end
  end

  // request driver
  int send_gap = 0;
  always @(negedge clk_i) begin
    request_t rq;
    if (!in_valid_i || item_taken) begin
      item_taken = 0;
      if (!no_idle && send_gap == 0 && $urandom_range(0, 9) == 0)
        send_gap = $urandom_range(1, 14);
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending.size() > 0) begin
        rq = pending.pop_front();
        mode_i <= rq.mode;
        base_frame_i <= rq.base_frame;
        run_len_i <= rq.run_len;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result receiver
  int recv_gap = 0;
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready_i <= 1'b0;
    end else begin
      if (!no_idle && recv_gap == 0 && $urandom_range(0, 9) == 0)
        recv_gap = $urandom_range(1, 14);
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic push(mode_e m, int unsigned sf, int unsigned nf);
    pending.push_back(request_t'{m, sf[15:0], nf[16:0]});
  endtask

  task automatic settle();
    do @(negedge clk_i);
    while (pending.size() != 0 || in_valid_i || grants_due.size() != 0);
    repeat (300) @(negedge clk_i);
  endtask

  task automatic write_range(cfg_idx_e idx, int unsigned val);
    @(negedge clk_i);
    cfg_taken = 0;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val[16:0];
    do @(negedge clk_i);
    while (!cfg_taken);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_window(int unsigned rs, int unsigned re);
    write_range(CFG_RANGE_START, rs);
    write_range(CFG_RANGE_END, re);
  endtask

  // mostly well-formed traffic inside the window, with some stray runs
  task automatic random_phase(int unsigned rs, int unsigned re, int n);
    int unsigned span, base, pick, len;
    span = (re > rs) ? re - rs : 64;
    base = (re > rs) ? rs : re;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, span) : $urandom_range(0, 48);
        push(MODE_ALLOC, 0, len);
      end else if (pick < 78) begin
        push(MODE_FREE, (base + $urandom_range(0, span - 1)) & 16'hffff, $urandom_range(1, 96));
      end else if (pick < 90) begin
        push(MODE_MARK, (base + $urandom_range(0, span - 1)) & 16'hffff, $urandom_range(1, 32));
      end else if (pick < 94) begin
        push(MODE_NOP, $urandom_range(0, 65535), $urandom_range(0, 65536));
      end else if (pick < 97) begin
        push(MODE_FREE, base & 16'hffff, span);
      end else begin
        push($urandom_range(0, 1) ? MODE_FREE : MODE_MARK, $urandom_range(0, 65535),
             $urandom_range(0, 65536));
      end
    end
  endtask

  int unsigned win_lo [8] = '{0, 100, 4096, 60000, 0, 1000, 3000, 0};
  int unsigned win_hi [8] = '{4096, 2000, 8192, 65536, 65536, 1064, 1000, 640};
  int win_items [8] = '{110, 110, 110, 100, 40, 110, 60, 187};

  initial begin
    foreach (used_map[w]) used_map[w] = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed checks on the full default window
    push(MODE_ALLOC, 0, 0);
    push(MODE_ALLOC, 0, 1);
    push(MODE_ALLOC, 0, 65536);
    push(MODE_MARK, 65500, 1000);
    push(MODE_FREE, 0, 65536);
    push(MODE_ALLOC, 0, 65536);
    push(MODE_ALLOC, 0, 1);
    push(MODE_FREE, 65535, 1);
    push(MODE_ALLOC, 0, 1);
    push(MODE_NOP, 65535, 131071);
    push(MODE_FREE, 0, 65536);
    push(MODE_ALLOC, 0, 64);
    push(MODE_MARK, 100, 1);
    push(MODE_ALLOC, 0, 200);
    push(MODE_FREE, 32768, 16384);
    settle();
    // inverted, empty and top-of-map windows
    set_window(5000, 1000);
    push(MODE_ALLOC, 0, 0);
    push(MODE_ALLOC, 0, 5);
    settle();
    set_window(700, 700);
    push(MODE_ALLOC, 0, 0);
    settle();
    set_window(65536, 65536);
    push(MODE_ALLOC, 0, 0);
    push(MODE_MARK, 65535, 2);
    settle();
    set_window(65000, 65536);
    push(MODE_ALLOC, 0, 0);
    push(MODE_ALLOC, 0, 600);
    push(MODE_FREE, 0, 65536);
    settle();

    for (int p = 0; p < 8; p++) begin
      set_window(win_lo[p], win_hi[p]);
      if (p == 7) no_idle = 1;
      random_phase(win_lo[p], win_hi[p], win_items[p]);
      // let the block back up behind a stalled receiver
      if (p == 1) hold_cycles = 600;
      settle();
    end

    $display("%0d requests, %0d results, %0d range writes", n_items, n_grants, n_cfg);
    $display("allocations granted %0d, refused %0d", n_alloc_ok, n_alloc_fail);
    if (errors == 0 && grants_due.size() == 0)
      $display("bitmap_frame_allocator_top: match");
    else
      $display("bitmap_frame_allocator_top: mismatch");
    $finish;
  end

endmodule
`default_nettype wire
